/* rtl/lens_distortion_chromatic_warp_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the lens distortion warp
// Each macro expands to a labelled concurrent assertion, or to nothing when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef LENS_DISTORTION_CHROMATIC_WARP_ASSERT_SVH
`define LENS_DISTORTION_CHROMATIC_WARP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LDCW_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("ldcw: assertion failed");
`define LDCW_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("ldcw: assertion failed");
`else
`define LDCW_ASSERT(lbl, clk, rst_n, prop)
`define LDCW_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* rtl/ldcw_pkg.sv */
// ----------------------------------------------------------------------------
// ldcw_pkg
// Widths, register indexes, stage records and fixed-point helpers shared by
// the lens distortion warp.
// ----------------------------------------------------------------------------
package ldcw_pkg;

	localparam int COORD_FRAC_BITS = 16;
	localparam int COEFF_FRAC_BITS = 14;
	localparam int COORD_W = 17;
	localparam int OUT_W = 19;
	localparam int LEN_FRAC = 24;
	localparam int RECIP_FRAC = 16;
	localparam int OUT_SHIFT = LEN_FRAC + RECIP_FRAC - COORD_FRAC_BITS;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int AB_W = 48;
	localparam int MAG_W = 31;
	localparam int SQRT_STAGES = 16;
	localparam int FRONT_STAGES = 6;
	localparam int POLY_STAGES = 11;
	localparam int CHROMA_STAGES = 4;
	localparam int PIPE_DEPTH = FRONT_STAGES + SQRT_STAGES + POLY_STAGES + CHROMA_STAGES;
	localparam int FILL_W = $clog2(PIPE_DEPTH + 1);

	typedef logic signed [31:0] len_t;
	typedef logic [MAG_W-1:0] mag_t;

	localparam mag_t MAG_MAX = '1;
	localparam len_t LEN_MAX_S = 32'sh7FFF_FFFF;
	localparam logic signed [63:0] LEN_HI = 64'sd2147483647;
	localparam logic [63:0] OUT_POS_MAX = (64'd1 << (OUT_W - 1)) - 64'd1;
	localparam logic [63:0] OUT_NEG_MAG = 64'd1 << (OUT_W - 1);
	localparam logic signed [OUT_W-1:0] OUT_MAX_V = {1'b0, {(OUT_W - 1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN_V = {1'b1, {(OUT_W - 1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VIEW_SIZE          = 3'd0,
		REG_INV_VIEW_SIZE      = 3'd1,
		REG_LENS_CENTER_LEFT   = 3'd2,
		REG_LENS_CENTER_RIGHT  = 3'd3,
		REG_WARP_SCALE_PAIR    = 3'd4,
		REG_WARP_COEFFS        = 3'd5,
		REG_ABERRATION_COEFFS  = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [63:0]     view_size;
		logic [63:0]     inv_view_size;
		logic [63:0]     lens_center_left;
		logic [63:0]     lens_center_right;
		logic [63:0]     warp_scale_pair;
		logic [63:0]     warp_coeffs;
		logic [AB_W-1:0] aberration_coeffs;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		logic        eye;
		len_t        n0;
		len_t        n1;
		logic [62:0] sq;
	} front_t;

	typedef struct packed {
		logic        valid;
		logic        eye;
		len_t        n0;
		len_t        n1;
		logic [31:0] root;
	} root_t;

	typedef struct packed {
		logic valid;
		logic eye;
		len_t rd0;
		len_t rd1;
	} warp_t;

	// Product magnitude shifted right and limited to the largest length.
	function automatic mag_t shift_sat(input logic [63:0] prod, input int unsigned sh);
		logic [63:0] s;
		s = prod >> sh;
		if (s > 64'(MAG_MAX)) begin
			return MAG_MAX;
		end
		return s[MAG_W-1:0];
	endfunction

	function automatic len_t signed_len(input mag_t m, input logic neg);
		len_t v;
		v = len_t'({1'b0, m});
		return neg ? -v : v;
	endfunction

	// Lengths are kept symmetric, so the magnitude always fits.
	function automatic mag_t mag_of(input len_t x);
		len_t a;
		a = x[31] ? -x : x;
		return a[MAG_W-1:0];
	endfunction

	function automatic len_t clamp_len(input logic signed [63:0] x);
		if (x > LEN_HI) begin
			return LEN_MAX_S;
		end
		if (x < -LEN_HI) begin
			return -LEN_MAX_S;
		end
		return x[31:0];
	endfunction

	function automatic len_t coeff_len(input logic [15:0] f);
		len_t v;
		v = len_t'($signed(f));
		return v <<< (LEN_FRAC - COEFF_FRAC_BITS);
	endfunction

endpackage

/* rtl/ldcw_if.sv */
// ----------------------------------------------------------------------------
// ldcw channel interfaces
// Coordinate input, warped result output and register write channels, each
// with valid and ready.
// ----------------------------------------------------------------------------
interface ldcw_in_if;
	logic                           valid;
	logic                           ready;
	logic                           eye;
	logic [ldcw_pkg::COORD_W-1:0]   coord_u;
	logic [ldcw_pkg::COORD_W-1:0]   coord_v;
	modport source (output valid, eye, coord_u, coord_v, input ready);
	modport sink (input valid, eye, coord_u, coord_v, output ready);
endinterface

interface ldcw_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [ldcw_pkg::OUT_W-1:0]    red_u;
	logic signed [ldcw_pkg::OUT_W-1:0]    red_v;
	logic signed [ldcw_pkg::OUT_W-1:0]    green_u;
	logic signed [ldcw_pkg::OUT_W-1:0]    green_v;
	logic signed [ldcw_pkg::OUT_W-1:0]    blue_u;
	logic signed [ldcw_pkg::OUT_W-1:0]    blue_v;
	logic                                 clipped;
	modport source (output valid, red_u, red_v, green_u, green_v, blue_u, blue_v, clipped,
		input ready);
	modport sink (input valid, red_u, red_v, green_u, green_v, blue_u, blue_v, clipped,
		output ready);
endinterface

interface ldcw_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [ldcw_pkg::CFG_IDX_W-1:0]   index;
	logic [ldcw_pkg::CFG_DATA_W-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/ldcw_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ldcw_cfg_regs
// Register file for the warp setup, written one register per item.
// ----------------------------------------------------------------------------
module ldcw_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	ldcw_cfg_if.sink        cfg,
	output ldcw_pkg::cfg_t  regs
);
	import ldcw_pkg::*;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_VIEW_SIZE: regs.view_size <= cfg.data;
				REG_INV_VIEW_SIZE: regs.inv_view_size <= cfg.data;
				REG_LENS_CENTER_LEFT: regs.lens_center_left <= cfg.data;
				REG_LENS_CENTER_RIGHT: regs.lens_center_right <= cfg.data;
				REG_WARP_SCALE_PAIR: regs.warp_scale_pair <= cfg.data;
				REG_WARP_COEFFS: regs.warp_coeffs <= cfg.data;
				REG_ABERRATION_COEFFS: regs.aberration_coeffs <= cfg.data[AB_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

/* rtl/ldcw_front.sv */
// ----------------------------------------------------------------------------
// ldcw_front
// Scales the coordinate to metres, removes the lens centre, normalises by
// the warp scale and forms the squared radius.
// ----------------------------------------------------------------------------
module ldcw_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  ldcw_pkg::cfg_t                 regs,
	input  logic                           in_valid,
	input  logic                           eye,
	input  logic [ldcw_pkg::COORD_W-1:0]   coord_u,
	input  logic [ldcw_pkg::COORD_W-1:0]   coord_v,
	output ldcw_pkg::front_t               fr
);
	import ldcw_pkg::*;

	localparam int P_W = COORD_W + 32;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic e_s1, e_s2, e_s3, e_s4, e_s5, e_s6;
	logic [P_W-1:0] p0_s1, p1_s1;
	len_t d0_s2, d1_s2;
	logic [62:0] np0_s3, np1_s3;
	logic nn0_s3, nn1_s3;
	len_t n0_s4, n1_s4;
	len_t n0_s5, n1_s5;
	logic [61:0] sa_s5, sb_s5;
	len_t n0_s6, n1_s6;
	logic [62:0] sq_s6;
	logic [31:0] lc0, lc1;

	assign lc0 = e_s1 ? regs.lens_center_right[31:0] : regs.lens_center_left[31:0];
	assign lc1 = e_s1 ? regs.lens_center_right[63:32] : regs.lens_center_left[63:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
		end else if (adv) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= {in_valid, v_s1, v_s2, v_s3, v_s4, v_s5};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			{e_s1, e_s2, e_s3, e_s4, e_s5, e_s6} <= {eye, e_s1, e_s2, e_s3, e_s4, e_s5};
			p0_s1 <= coord_u * regs.view_size[31:0];
			p1_s1 <= coord_v * regs.view_size[63:32];
			d0_s2 <= clamp_len(64'(p0_s1 >> COORD_FRAC_BITS) - 64'(lc0));
			d1_s2 <= clamp_len(64'(p1_s1 >> COORD_FRAC_BITS) - 64'(lc1));
			np0_s3 <= mag_of(d0_s2) * regs.warp_scale_pair[63:32];
			np1_s3 <= mag_of(d1_s2) * regs.warp_scale_pair[63:32];
			nn0_s3 <= d0_s2[31];
			nn1_s3 <= d1_s2[31];
			n0_s4 <= signed_len(shift_sat(64'(np0_s3), RECIP_FRAC), nn0_s3);
			n1_s4 <= signed_len(shift_sat(64'(np1_s3), RECIP_FRAC), nn1_s3);
			sa_s5 <= mag_of(n0_s4) * mag_of(n0_s4);
			sb_s5 <= mag_of(n1_s4) * mag_of(n1_s4);
			n0_s5 <= n0_s4;
			n1_s5 <= n1_s4;
			sq_s6 <= 63'(sa_s5) + 63'(sb_s5);
			n0_s6 <= n0_s5;
			n1_s6 <= n1_s5;
		end
	end

	assign fr.valid = v_s6;
	assign fr.eye = e_s6;
	assign fr.n0 = n0_s6;
	assign fr.n1 = n1_s6;
	assign fr.sq = sq_s6;

endmodule

/* rtl/ldcw_isqrt.sv */
// ----------------------------------------------------------------------------
// ldcw_isqrt
// Pipelined digit-by-digit integer square root, two root bits per stage.
// ----------------------------------------------------------------------------
module ldcw_isqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  ldcw_pkg::front_t  fr,
	output ldcw_pkg::root_t   rt
);
	import ldcw_pkg::*;

	typedef struct packed {
		logic [33:0] rem;
		logic [31:0] root;
	} sq_acc_t;

	function automatic sq_acc_t sqrt_step(input sq_acc_t a, input logic [1:0] pair);
		sq_acc_t r;
		logic [35:0] rs;
		logic [35:0] trial;
		rs = {a.rem, pair};
		trial = {2'b00, a.root, 2'b01};
		if (rs >= trial) begin
			r.rem = 34'(rs - trial);
			r.root = {a.root[30:0], 1'b1};
		end else begin
			r.rem = rs[33:0];
			r.root = {a.root[30:0], 1'b0};
		end
		return r;
	endfunction

	logic    valid_s[SQRT_STAGES];
	logic    eye_s[SQRT_STAGES];
	len_t    n0_s[SQRT_STAGES];
	len_t    n1_s[SQRT_STAGES];
	sq_acc_t acc_s[SQRT_STAGES];
	sq_acc_t acc_nx[SQRT_STAGES];
	logic [62:0] sq_s[SQRT_STAGES-1];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		sq_acc_t a_in, mid;
		logic [63:0] x_in;
		if (k == 0) begin : g_head
			assign a_in = '0;
			assign x_in = {1'b0, fr.sq};
		end else begin : g_body
			assign a_in = acc_s[k-1];
			assign x_in = {1'b0, sq_s[k-1]};
		end
		assign mid = sqrt_step(a_in, x_in[63-4*k -: 2]);
		assign acc_nx[k] = sqrt_step(mid, x_in[61-4*k -: 2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SQRT_STAGES; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else if (adv) begin
			valid_s[0] <= fr.valid;
			for (int k = 1; k < SQRT_STAGES; k++) begin
				valid_s[k] <= valid_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			eye_s[0] <= fr.eye;
			n0_s[0] <= fr.n0;
			n1_s[0] <= fr.n1;
			sq_s[0] <= fr.sq;
			for (int k = 1; k < SQRT_STAGES; k++) begin
				eye_s[k] <= eye_s[k-1];
				n0_s[k] <= n0_s[k-1];
				n1_s[k] <= n1_s[k-1];
			end
			for (int k = 1; k < SQRT_STAGES - 1; k++) begin
				sq_s[k] <= sq_s[k-1];
			end
			for (int k = 0; k < SQRT_STAGES; k++) begin
				acc_s[k] <= acc_nx[k];
			end
		end
	end

	assign rt.valid = valid_s[SQRT_STAGES-1];
	assign rt.eye = eye_s[SQRT_STAGES-1];
	assign rt.n0 = n0_s[SQRT_STAGES-1];
	assign rt.n1 = n1_s[SQRT_STAGES-1];
	assign rt.root = acc_s[SQRT_STAGES-1].root;

endmodule

/* rtl/ldcw_poly.sv */
// ----------------------------------------------------------------------------
// ldcw_poly
// Evaluates the cubic warp polynomial of the radius by Horner's rule and
// scales the normalised vector by it and by the warp scale.
// ----------------------------------------------------------------------------
module ldcw_poly (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  ldcw_pkg::cfg_t   regs,
	input  ldcw_pkg::root_t  rt,
	output ldcw_pkg::warp_t  wp
);
	import ldcw_pkg::*;

	localparam int H_STEPS = 3;
	localparam int H_STAGES = 2 * H_STEPS;

	logic v_s1;
	logic e_s1;
	mag_t r_s1;
	len_t acc_s1, n0_s1, n1_s1;

	logic cv_s[H_STAGES];
	logic ce_s[H_STAGES];
	mag_t cr_s[H_STAGES];
	len_t cn0_s[H_STAGES];
	len_t cn1_s[H_STAGES];

	logic [61:0] hp_s[H_STEPS];
	logic        hn_s[H_STEPS];
	len_t        ha_s[H_STEPS];
	logic [61:0] hp_nx[H_STEPS];
	logic        hn_nx[H_STEPS];
	len_t        ha_nx[H_STEPS];

	logic v_s8, v_s9, v_s10, v_s11;
	logic e_s8, e_s9, e_s10, e_s11;
	logic [61:0] tp0_s8, tp1_s8;
	logic tn0_s8, tn1_s8;
	len_t t0_s9, t1_s9;
	logic [62:0] rp0_s10, rp1_s10;
	logic rn0_s10, rn1_s10;
	len_t rd0_s11, rd1_s11;
	len_t poly;

	for (genvar j = 0; j < H_STEPS; j++) begin : g_horner
		len_t acc_in;
		mag_t r_in;
		if (j == 0) begin : g_head
			assign acc_in = acc_s1;
			assign r_in = r_s1;
		end else begin : g_body
			assign acc_in = ha_s[j-1];
			assign r_in = cr_s[2*j-1];
		end
		assign hp_nx[j] = mag_of(acc_in) * r_in;
		assign hn_nx[j] = acc_in[31];
		assign ha_nx[j] = clamp_len(64'(signed_len(shift_sat(64'(hp_s[j]), LEN_FRAC), hn_s[j]))
			+ 64'(coeff_len(regs.warp_coeffs[16*(j+1) +: 16])));
	end

	assign poly = ha_s[H_STEPS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int k = 0; k < H_STAGES; k++) begin
				cv_s[k] <= 1'b0;
			end
			{v_s8, v_s9, v_s10, v_s11} <= '0;
		end else if (adv) begin
			v_s1 <= rt.valid;
			cv_s[0] <= v_s1;
			for (int k = 1; k < H_STAGES; k++) begin
				cv_s[k] <= cv_s[k-1];
			end
			{v_s8, v_s9, v_s10, v_s11} <= {cv_s[H_STAGES-1], v_s8, v_s9, v_s10};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s1 <= rt.eye;
			r_s1 <= rt.root[31] ? MAG_MAX : rt.root[MAG_W-1:0];
			acc_s1 <= coeff_len(regs.warp_coeffs[15:0]);
			n0_s1 <= rt.n0;
			n1_s1 <= rt.n1;
			ce_s[0] <= e_s1;
			cr_s[0] <= r_s1;
			cn0_s[0] <= n0_s1;
			cn1_s[0] <= n1_s1;
			for (int k = 1; k < H_STAGES; k++) begin
				ce_s[k] <= ce_s[k-1];
				cr_s[k] <= cr_s[k-1];
				cn0_s[k] <= cn0_s[k-1];
				cn1_s[k] <= cn1_s[k-1];
			end
			for (int j = 0; j < H_STEPS; j++) begin
				hp_s[j] <= hp_nx[j];
				hn_s[j] <= hn_nx[j];
				ha_s[j] <= ha_nx[j];
			end
			{e_s8, e_s9, e_s10, e_s11} <= {ce_s[H_STAGES-1], e_s8, e_s9, e_s10};
			tp0_s8 <= mag_of(cn0_s[H_STAGES-1]) * mag_of(poly);
			tp1_s8 <= mag_of(cn1_s[H_STAGES-1]) * mag_of(poly);
			tn0_s8 <= cn0_s[H_STAGES-1][31] ^ poly[31];
			tn1_s8 <= cn1_s[H_STAGES-1][31] ^ poly[31];
			t0_s9 <= signed_len(shift_sat(64'(tp0_s8), LEN_FRAC), tn0_s8);
			t1_s9 <= signed_len(shift_sat(64'(tp1_s8), LEN_FRAC), tn1_s8);
			rp0_s10 <= mag_of(t0_s9) * regs.warp_scale_pair[31:0];
			rp1_s10 <= mag_of(t1_s9) * regs.warp_scale_pair[31:0];
			rn0_s10 <= t0_s9[31];
			rn1_s10 <= t1_s9[31];
			rd0_s11 <= signed_len(shift_sat(64'(rp0_s10), LEN_FRAC), rn0_s10);
			rd1_s11 <= signed_len(shift_sat(64'(rp1_s10), LEN_FRAC), rn1_s10);
		end
	end

	assign wp.valid = v_s11;
	assign wp.eye = e_s11;
	assign wp.rd0 = rd0_s11;
	assign wp.rd1 = rd1_s11;

endmodule

/* rtl/ldcw_chroma.sv */
// ----------------------------------------------------------------------------
// ldcw_chroma
// Applies the red, green and blue aberration factors, restores the lens
// centre, converts to viewport coordinates and saturates into the output
// register.
// ----------------------------------------------------------------------------
module ldcw_chroma (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  ldcw_pkg::cfg_t   regs,
	input  ldcw_pkg::warp_t  wp,
	ldcw_out_if.source       result
);
	import ldcw_pkg::*;

	localparam int LANES = 6;

	logic v_s1, v_s2, v_s3;
	logic e_s1;
	logic [46:0] p1_s[LANES];
	logic        n1_s[LANES];
	len_t        t_s2[LANES];
	logic [62:0] p3_s[LANES];
	logic        n3_s[LANES];

	len_t        t_nx[LANES];
	logic [46:0] p1_nx[LANES];
	logic        n1_nx[LANES];
	logic signed [OUT_W-1:0] lane_val[LANES];
	logic        lane_clip[LANES];

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		localparam int C = l / 2;
		localparam int I = l % 2;
		len_t rd;
		logic [31:0] lc;
		logic [63:0] m;
		assign rd = (I == 0) ? wp.rd0 : wp.rd1;
		assign p1_nx[l] = mag_of(rd) * regs.aberration_coeffs[16*C +: 16];
		assign n1_nx[l] = rd[31];
		assign lc = e_s1 ? regs.lens_center_right[32*I +: 32] : regs.lens_center_left[32*I +: 32];
		assign t_nx[l] = clamp_len(64'(signed_len(shift_sat(64'(p1_s[l]), COEFF_FRAC_BITS),
			n1_s[l])) + 64'(lc));
		assign m = 64'(p3_s[l]) >> OUT_SHIFT;
		assign lane_clip[l] = n3_s[l] ? (m > OUT_NEG_MAG) : (m > OUT_POS_MAX);
		assign lane_val[l] = lane_clip[l] ? (n3_s[l] ? OUT_MIN_V : OUT_MAX_V)
			: (n3_s[l] ? -$signed(m[OUT_W-1:0]) : $signed(m[OUT_W-1:0]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3} <= '0;
			result.valid <= 1'b0;
		end else if (adv) begin
			{v_s1, v_s2, v_s3} <= {wp.valid, v_s1, v_s2};
			result.valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s1 <= wp.eye;
			for (int l = 0; l < LANES; l++) begin
				p1_s[l] <= p1_nx[l];
				n1_s[l] <= n1_nx[l];
				t_s2[l] <= t_nx[l];
				p3_s[l] <= mag_of(t_s2[l]) * regs.inv_view_size[32*(l%2) +: 32];
				n3_s[l] <= t_s2[l][31];
			end
			result.red_u <= lane_val[0];
			result.red_v <= lane_val[1];
			result.green_u <= lane_val[2];
			result.green_v <= lane_val[3];
			result.blue_u <= lane_val[4];
			result.blue_v <= lane_val[5];
			result.clipped <= lane_clip[0] | lane_clip[1] | lane_clip[2] | lane_clip[3]
				| lane_clip[4] | lane_clip[5];
		end
	end

endmodule

/* rtl/lens_distortion_chromatic_warp.sv */
// ----------------------------------------------------------------------------
// lens_distortion_chromatic_warp
// Radial polynomial lens warp with per-channel chromatic aberration.
//
// Channel  Role                 Payload
// coord    item in              eye, coord_u, coord_v
// result   item out             red/green/blue u and v, clipped
// cfg      register write       index, data
//
// One item is accepted per cycle while no result waits unaccepted; each item
// passes 37 register stages, the last being the output register. The depth
// is set by the 16 two-bit square root stages and the chain of registered
// multiplies around them.
// Reset clears all valid bits and the configuration registers.
// While a result waits unaccepted the whole pipeline holds and coord is not
// ready; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "lens_distortion_chromatic_warp_assert.svh"

module lens_distortion_chromatic_warp (
	input  logic      clk,
	input  logic      arst_n,
	ldcw_in_if.sink   coord,
	ldcw_out_if.source result,
	ldcw_cfg_if.sink  cfg
);
	import ldcw_pkg::*;

	logic adv;
	cfg_t regs;
	front_t fr;
	root_t rt;
	warp_t wp;
	logic [FILL_W-1:0] inflight_q;

	assign adv = !result.valid || result.ready;
	assign coord.ready = adv;

	ldcw_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	ldcw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.regs     (regs),
		.in_valid (coord.valid),
		.eye      (coord.eye),
		.coord_u  (coord.coord_u),
		.coord_v  (coord.coord_v),
		.fr       (fr)
	);

	ldcw_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.fr     (fr),
		.rt     (rt)
	);

	ldcw_poly u_poly (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.regs   (regs),
		.rt     (rt),
		.wp     (wp)
	);

	ldcw_chroma u_chroma (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.regs   (regs),
		.wp     (wp),
		.result (result)
	);

	// Items accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + FILL_W'(coord.valid && coord.ready)
				- FILL_W'(result.valid && result.ready);
		end
	end

	`LDCW_ASSERT(a_fill_bound, clk, arst_n, inflight_q <= FILL_W'(PIPE_DEPTH))
	`LDCW_ASSERT(a_out_has_item, clk, arst_n, result.valid |-> (inflight_q != '0))
	`LDCW_ASSERT(a_full_drains, clk, arst_n, (inflight_q == FILL_W'(PIPE_DEPTH) && coord.valid && coord.ready) |-> (result.valid && result.ready))

endmodule
